### sv/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int ACTION_W    = 2;
  localparam int RUN_FIELD_W = 4;
  localparam int KEY_W       = 31;
  localparam int TAG_W       = 32;
  localparam int REC_W       = KEY_W + TAG_W;

  // Width of a run index before range checking; holds the largest WAYS.
  localparam int IDX_W       = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  localparam logic STATUS_RECORD    = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT
  } state_t;

endpackage

### sv/kwm_if.sv
// ----------------------------------------------------------------------------
// kwm_if
// Valid/ready channels for commands into and records out of the merge block.
// ----------------------------------------------------------------------------
interface kwm_in_if;
  logic                             valid;
  logic                             ready;
  logic [kwm_pkg::ACTION_W-1:0]     action;
  logic [kwm_pkg::RUN_FIELD_W-1:0]  run_index;
  logic [kwm_pkg::KEY_W-1:0]        record_key;
  logic [kwm_pkg::TAG_W-1:0]        record_tag;

  modport source (output valid, action, run_index, record_key, record_tag, input ready);
  modport sink   (input valid, action, run_index, record_key, record_tag, output ready);
endinterface

interface kwm_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [kwm_pkg::KEY_W-1:0]        out_key;
  logic [kwm_pkg::TAG_W-1:0]        out_tag;
  logic [kwm_pkg::RUN_FIELD_W-1:0]  out_run;
  logic                             final_record;

  modport source (output valid, status, out_key, out_tag, out_run, final_record,
                  input ready);
  modport sink   (input valid, status, out_key, out_tag, out_run, final_record,
                  output ready);
endinterface

### sv/k_way_merge_of_sorted_runs_top.sv
// ----------------------------------------------------------------------------
// k_way_merge_of_sorted_runs_top
// Merge pass of an external sort over up to WAYS runs of RUN_DEPTH records.
// ----------------------------------------------------------------------------
// Commands arrive on in_ch, one transfer per command. A load appends a
// record to the tail of its run; a load naming a run at or above WAYS, or
// into a run that already holds RUN_DEPTH records since the last clear, is
// dropped. A clear empties every run at once. In a pop the heads of the
// runs are read one run per cycle through the single read port of the
// record memory and compared against the best so far, then the winner is
// handed to the output register and its run advances. Ties on key go to the
// lower run index. A pop with nothing left returns status exhausted with all
// other fields zero. Loads and clears give no result. The output register
// holds a finished record while the next commands are taken; a pop only
// waits at its end if that register is still full. No clearing pass is
// needed after reset: read positions and fill counts sit in flip-flops, and
// only reads of filled entries of the record memory are used.
// ----------------------------------------------------------------------------
module k_way_merge_of_sorted_runs_top #(
  parameter int WAYS      = 16,
  parameter int RUN_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  kwm_in_if.sink    in_ch,
  kwm_out_if.source out_ch
);

  localparam int RUN_W  = $clog2(WAYS);
  localparam int CNT_W  = $clog2(RUN_DEPTH + 1);
  localparam int ENTRIES = WAYS * RUN_DEPTH;
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int TOT_W  = $clog2(ENTRIES + 1);
  localparam int IDX_W  = kwm_pkg::IDX_W;
  localparam int KEY_W  = kwm_pkg::KEY_W;
  localparam int TAG_W  = kwm_pkg::TAG_W;
  localparam int REC_W  = kwm_pkg::REC_W;

  localparam logic [RUN_W-1:0] LAST_RUN = RUN_W'(WAYS - 1);

  kwm_pkg::state_t state, state_next;

  // Per-run read position and fill count, cleared by reset and by clear.
  logic [CNT_W-1:0]  rd_pos [WAYS];
  logic [CNT_W-1:0]  fill   [WAYS];
  logic [TOT_W-1:0]  total;        // unread records over all runs

  // Scan of the run heads.
  logic [RUN_W-1:0]  scan_idx;
  logic [ADDR_W-1:0] scan_base;    // scan_idx * RUN_DEPTH
  logic              p_valid;      // head read last cycle is live
  logic [RUN_W-1:0]  p_run;

  // Best head so far.
  logic              best_found;
  logic [KEY_W-1:0]  best_key;
  logic [TAG_W-1:0]  best_tag;
  logic [RUN_W-1:0]  best_run;

  // Output register.
  logic              out_valid;
  logic              out_status;
  logic [KEY_W-1:0]  out_key;
  logic [TAG_W-1:0]  out_tag;
  logic [kwm_pkg::RUN_FIELD_W-1:0] out_run;
  logic              out_final;

  logic              in_ready, in_fire, emit;
  kwm_pkg::action_t  act;
  logic [IDX_W-1:0]  load_run;
  logic [RUN_W-1:0]  load_sel, cnt_sel;
  logic [CNT_W-1:0]  rd_sel, fill_sel;
  logic              head_live, load_ok;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [REC_W-1:0]  wdata, rdata;
  logic [KEY_W-1:0]  rkey;
  logic [TAG_W-1:0]  rtag;

  // --------------------------------------------------------------------------
  // Command decode and count lookup
  // --------------------------------------------------------------------------
  assign in_ready = (state == kwm_pkg::ST_IDLE);
  assign in_fire  = in_ch.valid && in_ready;
  assign act      = kwm_pkg::action_t'(in_ch.action);

  assign load_run = IDX_W'(in_ch.run_index);
  assign load_sel = load_run[RUN_W-1:0];

  // The count arrays are looked up at one place a cycle: the scanned run
  // while scanning, the addressed run otherwise.
  assign cnt_sel  = (state == kwm_pkg::ST_SCAN) ? scan_idx : load_sel;
  assign rd_sel   = rd_pos[cnt_sel];
  assign fill_sel = fill[cnt_sel];

  assign head_live = rd_sel < fill_sel;

  assign load_ok = in_fire && (act == kwm_pkg::ACT_LOAD) &&
                   (load_run < IDX_W'(WAYS)) && (fill_sel < CNT_W'(RUN_DEPTH));

  // Record memory: key above tag.
  assign waddr = ADDR_W'(ADDR_W'(load_sel) * ADDR_W'(RUN_DEPTH)) + ADDR_W'(fill_sel);
  assign wdata = {in_ch.record_key, in_ch.record_tag};
  assign raddr = scan_base + ADDR_W'(rd_sel);

  kwm_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (load_ok),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rkey = rdata[REC_W-1:TAG_W];
  assign rtag = rdata[TAG_W-1:0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    case (state)
      kwm_pkg::ST_IDLE: begin
        if (in_fire && (act == kwm_pkg::ACT_POP)) begin
          state_next = kwm_pkg::ST_SCAN;
        end
      end
      kwm_pkg::ST_SCAN: begin
        if (scan_idx == LAST_RUN) begin
          state_next = kwm_pkg::ST_TAIL;
        end
      end
      kwm_pkg::ST_TAIL: begin
        // the last head read lands and is compared this cycle
        state_next = kwm_pkg::ST_EMIT;
      end
      kwm_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid || out_ch.ready) begin
          emit       = 1'b1;
          state_next = kwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state: counts, scan, best and output valid
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WAYS; i++) begin
        rd_pos[i] <= '0;
        fill[i]   <= '0;
      end
      total      <= '0;
      scan_idx   <= '0;
      scan_base  <= '0;
      p_valid    <= 1'b0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // start of a pop: restart the scan from run zero
      if (in_fire && (act == kwm_pkg::ACT_POP)) begin
        scan_idx   <= '0;
        scan_base  <= '0;
        best_found <= 1'b0;
      end

      if (in_fire && (act == kwm_pkg::ACT_CLEAR)) begin
        for (int i = 0; i < WAYS; i++) begin
          rd_pos[i] <= '0;
          fill[i]   <= '0;
        end
        total <= '0;
      end

      if (load_ok) begin
        fill[load_sel] <= fill_sel + CNT_W'(1);
        total          <= total + TOT_W'(1);
      end

      // issue one head read a cycle; mark it live if the run has records
      if (state == kwm_pkg::ST_SCAN) begin
        p_valid   <= head_live;
        scan_idx  <= scan_idx + RUN_W'(1);
        scan_base <= scan_base + ADDR_W'(RUN_DEPTH);
      end else begin
        p_valid <= 1'b0;
      end

      // strict compare in rising run order keeps the lower run on ties
      if (p_valid && (!best_found || (rkey < best_key))) begin
        best_found <= 1'b1;
      end

      // advance the winning run and retire the record
      if (emit && best_found) begin
        rd_pos[best_run] <= rd_pos[best_run] + CNT_W'(1);
        total            <= total - TOT_W'(1);
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == kwm_pkg::ST_SCAN) begin
      p_run <= scan_idx;
    end

    if (p_valid && (!best_found || (rkey < best_key))) begin
      best_key <= rkey;
      best_tag <= rtag;
      best_run <= p_run;
    end

    if (emit) begin
      if (best_found) begin
        out_status <= kwm_pkg::STATUS_RECORD;
        out_key    <= best_key;
        out_tag    <= best_tag;
        out_run    <= kwm_pkg::RUN_FIELD_W'(best_run);
        out_final  <= (total == TOT_W'(1));
      end else begin
        out_status <= kwm_pkg::STATUS_EXHAUSTED;
        out_key    <= '0;
        out_tag    <= '0;
        out_run    <= '0;
        out_final  <= 1'b0;
      end
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.out_key      = out_key;
  assign out_ch.out_tag      = out_tag;
  assign out_ch.out_run      = out_run;
  assign out_ch.final_record = out_final;

endmodule

### sv/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/kwm_checker.sv
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks of the merge block, bound to the top level.
// ----------------------------------------------------------------------------
module kwm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [kwm_pkg::ACTION_W-1:0]    in_action,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_status,
  input logic [kwm_pkg::KEY_W-1:0]       out_key,
  input logic [kwm_pkg::TAG_W-1:0]       out_tag,
  input logic [kwm_pkg::RUN_FIELD_W-1:0] out_run,
  input logic                            out_final
);

  // a pending result stays offered until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // an exhausted pop carries no record
  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == kwm_pkg::STATUS_EXHAUSTED) |->
      (out_key == '0) && (out_tag == '0) && (out_run == '0) && !out_final)
    else $error("exhausted result carries record fields");

  // a pop holds off further commands while it scans
  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_action == kwm_pkg::ACT_POP) |=> !in_ready)
    else $error("command taken during a pop scan");

endmodule

bind k_way_merge_of_sorted_runs_top kwm_checker u_kwm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_action  (in_ch.action),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_key    (out_ch.out_key),
  .out_tag    (out_ch.out_tag),
  .out_run    (out_ch.out_run),
  .out_final  (out_ch.final_record)
);
